/* design/assert_macros.svh */
// Assertion helpers for the tokenizer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/clst_pkg.sv */
`timescale 1ns / 1ps
package clst_pkg;

  // Token kinds.
  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_KEYWORD = 5'd2;
  localparam logic [4:0] K_NUMBER  = 5'd3;
  localparam logic [4:0] K_STRING  = 5'd4;
  localparam logic [4:0] K_SEMI    = 5'd5;
  localparam logic [4:0] K_LPAREN  = 5'd6;
  localparam logic [4:0] K_RPAREN  = 5'd7;
  localparam logic [4:0] K_LBRACE  = 5'd8;
  localparam logic [4:0] K_RBRACE  = 5'd9;
  localparam logic [4:0] K_ADD     = 5'd10;
  localparam logic [4:0] K_SUB     = 5'd11;
  localparam logic [4:0] K_MUL     = 5'd12;
  localparam logic [4:0] K_DIV     = 5'd13;
  localparam logic [4:0] K_ASSIGN  = 5'd14;
  localparam logic [4:0] K_ADD_EQ  = 5'd15;
  localparam logic [4:0] K_SUB_EQ  = 5'd16;
  localparam logic [4:0] K_MUL_EQ  = 5'd17;
  localparam logic [4:0] K_DIV_EQ  = 5'd18;
  localparam logic [4:0] K_EQ      = 5'd19;
  localparam logic [4:0] K_LT      = 5'd20;
  localparam logic [4:0] K_LE      = 5'd21;
  localparam logic [4:0] K_GT      = 5'd22;
  localparam logic [4:0] K_GE      = 5'd23;
  localparam logic [4:0] K_NE      = 5'd24;
  localparam logic [4:0] K_UNKNOWN = 5'd25;

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  keyword_index;
    logic [31:0] number_value;
    logic [15:0] text_length;
    logic [31:0] line_number;
    logic [31:0] start_offset;
    logic        last;
  } tok_t;

  // Keyword text, left aligned, zero padded to ten characters.
  localparam logic [79:0] KW_TEXT [16] = '{
    {"if", 64'h0}, {"else", 48'h0}, {"for", 56'h0}, {"do", 64'h0},
    {"while", 40'h0}, {"char", 48'h0}, {"int", 56'h0}, {"return", 32'h0},
    {"quit", 48'h0}, {"print", 40'h0}, {"read", 48'h0}, {"break", 40'h0},
    {"begin", 40'h0}, {"function", 16'h0}, {"interprete"}, {"end", 56'h0}
  };

  localparam logic [3:0] KW_LEN [16] = '{
    4'd2, 4'd4, 4'd3, 4'd2, 4'd5, 4'd4, 4'd3, 4'd6,
    4'd4, 4'd5, 4'd4, 4'd5, 4'd5, 4'd8, 4'd10, 4'd3
  };

  // Character of a keyword at a position; zero past the end of the text.
  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [15:0] pos);
    logic [79:0] txt;
    logic [3:0]  p;
    txt = KW_TEXT[idx];
    p   = pos[3:0];
    if (pos < 16'd10) begin
      kw_char = txt[79 - 8 * p -: 8];
    end else begin
      kw_char = 8'h00;
    end
  endfunction

endpackage

/* design/clst_if.sv */
`timescale 1ns / 1ps
// Source byte channel.
interface clst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       is_end;

  modport source (output valid, output byte_req, output is_end, input ready);
  modport sink (input valid, input byte_req, input is_end, output ready);
endinterface

// Token channel.
interface clst_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [3:0]  keyword_index;
  logic [31:0] number_value;
  logic [15:0] text_length;
  logic [31:0] line_number;
  logic [31:0] start_offset;
  logic        last;

  modport source (output valid, output kind, output keyword_index, output number_value,
                  output text_length, output line_number, output start_offset,
                  output last, input ready);
  modport sink (input valid, input kind, input keyword_index, input number_value,
                input text_length, input line_number, input start_offset,
                input last, output ready);
endinterface

/* design/c_like_source_tokenizer_unit.sv */
`timescale 1ns / 1ps
// A token is written to the token queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the four-entry token queue has two free slots;
// a byte that yields two tokens writes both into the queue together.
// Reset (rst_ni low, asynchronous) returns the scanner to idle at offset 0, line 0,
// and empties the token queue.
`include "assert_macros.svh"
module c_like_source_tokenizer_unit #(
  parameter int NUMBER_BITS   = 32,
  parameter int KEYWORD_COUNT = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  clst_in_if.sink    in_i,
  clst_out_if.source out_o
);
  import clst_pkg::*;

  // Scanner modes.
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_DEC   = 4'd2;
  localparam logic [3:0] M_ZERO  = 4'd3;
  localparam logic [3:0] M_HEX   = 4'd4;
  localparam logic [3:0] M_OCT   = 4'd5;
  localparam logic [3:0] M_STR   = 4'd6;
  localparam logic [3:0] M_OP    = 4'd7;
  localparam logic [3:0] M_LINE  = 4'd8;
  localparam logic [3:0] M_BLOCK = 4'd9;
  localparam logic [3:0] M_BSTAR = 4'd10;

  logic [3:0]               mode_q, mode_d;
  logic [NUMBER_BITS-1:0]   value_q, value_d;
  logic [15:0]              length_q, length_d;
  logic [KEYWORD_COUNT-1:0] cand_q, cand_d;
  logic [4:0]               op_q, op_d;
  logic [31:0]              start_q, start_d;
  logic [31:0]              tline_q, tline_d;
  logic [31:0]              offset_q, offset_d;
  logic [31:0]              lines_q, lines_d;

  logic [7:0] b;
  logic       accept;
  logic       is_alpha, is_digit, is_oct;
  logic [3:0] hex_d;
  logic       hex_ok;
  logic [3:0] dig;
  logic [15:0] length_inc;

  // Pending token as it would be flushed from the current state.
  tok_t       flush_tok;
  logic       flush_has;
  logic       kw_hit;
  logic [3:0] kw_idx;
  logic [63:0] value_wide;

  tok_t       r0, r1, extra;
  logic [1:0] n_res;
  logic       absorbed, do_flush, has_extra;

  assign b      = in_i.byte_req;
  assign accept = in_i.valid && in_i.ready;

  // Byte classes.
  always_comb begin
    is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    is_digit = (b >= "0" && b <= "9");
    is_oct   = (b >= "0" && b <= "7");
    dig      = b[3:0];
    hex_ok   = 1'b1;
    if (is_digit) begin
      hex_d = b[3:0];
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      hex_d = 4'(b[3:0] + 4'd9);
    end else begin
      hex_d  = 4'd0;
      hex_ok = 1'b0;
    end
    length_inc = (length_q == 16'hFFFF) ? length_q : 16'(length_q + 16'd1);
  end

  // Keyword lookup: lowest index among surviving candidates of matching length.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 4'd0;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (cand_q[i] && ({12'd0, KW_LEN[4'(i)]} == length_q)) begin
        kw_hit = 1'b1;
        kw_idx = 4'(i);
      end
    end
  end

  // Token flushed from the pending state.
  always_comb begin
    value_wide = 64'(value_q);
    flush_tok              = '0;
    flush_tok.line_number  = tline_q;
    flush_tok.start_offset = start_q;
    flush_has              = 1'b1;
    case (mode_q)
      M_IDENT: begin
        flush_tok.kind          = kw_hit ? K_KEYWORD : K_IDENT;
        flush_tok.keyword_index = kw_hit ? kw_idx : 4'd0;
        flush_tok.text_length   = length_q;
      end
      M_DEC, M_ZERO, M_HEX, M_OCT: begin
        flush_tok.kind         = K_NUMBER;
        flush_tok.number_value = value_wide[31:0];
      end
      M_STR: begin
        flush_tok.kind        = K_STRING;
        flush_tok.text_length = length_q;
      end
      M_OP: begin
        flush_tok.kind = op_q;
      end
      default: begin
        flush_has = 1'b0;
      end
    endcase
  end

  // Next state and the results of one byte.
  always_comb begin
    mode_d    = mode_q;
    value_d   = value_q;
    length_d  = length_q;
    cand_d    = cand_q;
    op_d      = op_q;
    start_d   = start_q;
    tline_d   = tline_q;
    offset_d  = offset_q;
    lines_d   = lines_q;
    absorbed  = 1'b0;
    do_flush  = 1'b0;
    has_extra = 1'b0;
    extra              = '0;
    extra.line_number  = tline_q;
    extra.start_offset = start_q;
    r0    = '0;
    r1    = '0;
    n_res = 2'd0;

    if (in_i.is_end) begin
      // Flush, then the end token, then back to the reset state.
      extra.kind         = K_END;
      extra.line_number  = lines_q;
      extra.start_offset = offset_q;
      has_extra = 1'b1;
      do_flush  = flush_has;
      mode_d    = M_IDLE;
      value_d   = '0;
      length_d  = '0;
      cand_d    = '1;
      op_d      = '0;
      start_d   = '0;
      tline_d   = '0;
      offset_d  = '0;
      lines_d   = '0;
    end else begin
      // Feed the byte to the token in progress.
      case (mode_q)
        M_IDENT: begin
          if (is_alpha || is_digit || b == "_") begin
            absorbed = 1'b1;
            for (int i = 0; i < KEYWORD_COUNT; i++) begin
              if (kw_char(4'(i), length_q) != b) cand_d[i] = 1'b0;
            end
            length_d = length_inc;
          end
        end
        M_DEC: begin
          if (is_digit) begin
            absorbed = 1'b1;
            value_d  = (value_q << 3) + (value_q << 1) + NUMBER_BITS'(dig);
          end
        end
        M_ZERO: begin
          if (b == "x" || b == "X") begin
            absorbed = 1'b1;
            mode_d   = M_HEX;
          end else if (is_oct) begin
            absorbed = 1'b1;
            mode_d   = M_OCT;
            value_d  = (value_q << 3) + NUMBER_BITS'(dig);
          end
        end
        M_HEX: begin
          if (hex_ok) begin
            absorbed = 1'b1;
            value_d  = (value_q << 4) + NUMBER_BITS'(hex_d);
          end
        end
        M_OCT: begin
          if (is_oct) begin
            absorbed = 1'b1;
            value_d  = (value_q << 3) + NUMBER_BITS'(dig);
          end
        end
        M_STR: begin
          absorbed = 1'b1;
          if (b == "\"") begin
            do_flush = 1'b1;
            mode_d   = M_IDLE;
          end else begin
            length_d = length_inc;
          end
        end
        M_OP: begin
          if (op_q == K_DIV && b == "/") begin
            absorbed = 1'b1;
            mode_d   = M_LINE;
          end else if (op_q == K_DIV && b == "*") begin
            absorbed = 1'b1;
            mode_d   = M_BLOCK;
          end else if (b == "=") begin
            absorbed  = 1'b1;
            has_extra = 1'b1;
            mode_d    = M_IDLE;
            case (op_q)
              K_ADD:    extra.kind = K_ADD_EQ;
              K_SUB:    extra.kind = K_SUB_EQ;
              K_MUL:    extra.kind = K_MUL_EQ;
              K_DIV:    extra.kind = K_DIV_EQ;
              K_ASSIGN: extra.kind = K_EQ;
              K_LT:     extra.kind = K_LE;
              K_GT:     extra.kind = K_GE;
              default:  extra.kind = K_NE;
            endcase
          end
        end
        M_LINE: begin
          absorbed = 1'b1;
          if (b == "\n") mode_d = M_IDLE;
        end
        M_BLOCK: begin
          absorbed = 1'b1;
          if (b == "*") mode_d = M_BSTAR;
        end
        M_BSTAR: begin
          absorbed = 1'b1;
          if (b == "/") begin
            mode_d = M_IDLE;
          end else if (b == "*") begin
            mode_d = M_BSTAR;
          end else begin
            mode_d = M_BLOCK;
          end
        end
        default: begin
          absorbed = 1'b0;
        end
      endcase

      // A byte that ends the pending token flushes it and opens a new one.
      if (!absorbed) begin
        do_flush = flush_has;
        mode_d   = M_IDLE;
        start_d  = offset_q;
        tline_d  = lines_q;
        value_d  = '0;
        length_d = '0;
        extra.line_number  = lines_q;
        extra.start_offset = offset_q;
        if (b == " " || b == "\t" || b == "\n") begin
          mode_d = M_IDLE;
        end else if (is_alpha || b == "_") begin
          for (int i = 0; i < KEYWORD_COUNT; i++) begin
            cand_d[i] = (kw_char(4'(i), 16'd0) == b);
          end
          length_d = 16'd1;
          mode_d   = M_IDENT;
        end else if (is_digit) begin
          value_d = NUMBER_BITS'(dig);
          mode_d  = (b == "0") ? M_ZERO : M_DEC;
        end else begin
          case (b)
            "\"": mode_d = M_STR;
            ";": begin has_extra = 1'b1; extra.kind = K_SEMI; end
            "(": begin has_extra = 1'b1; extra.kind = K_LPAREN; end
            ")": begin has_extra = 1'b1; extra.kind = K_RPAREN; end
            "{": begin has_extra = 1'b1; extra.kind = K_LBRACE; end
            "}": begin has_extra = 1'b1; extra.kind = K_RBRACE; end
            "+": begin op_d = K_ADD; mode_d = M_OP; end
            "-": begin op_d = K_SUB; mode_d = M_OP; end
            "*": begin op_d = K_MUL; mode_d = M_OP; end
            "/": begin op_d = K_DIV; mode_d = M_OP; end
            "=": begin op_d = K_ASSIGN; mode_d = M_OP; end
            "<": begin op_d = K_LT; mode_d = M_OP; end
            ">": begin op_d = K_GT; mode_d = M_OP; end
            "!": begin op_d = K_UNKNOWN; mode_d = M_OP; end
            default: begin has_extra = 1'b1; extra.kind = K_UNKNOWN; end
          endcase
        end
      end

      if (b == "\n") lines_d = 32'(lines_q + 32'd1);
      offset_d = 32'(offset_q + 32'd1);
    end

    // Order the results and mark the final one.
    if (do_flush && has_extra) begin
      r0 = flush_tok;
      r1 = extra;
      r1.last = 1'b1;
      n_res = 2'd2;
    end else if (do_flush) begin
      r0 = flush_tok;
      r0.last = 1'b1;
      n_res = 2'd1;
    end else if (has_extra) begin
      r0 = extra;
      r0.last = 1'b1;
      n_res = 2'd1;
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      value_q  <= '0;
      length_q <= '0;
      cand_q   <= '1;
      op_q     <= '0;
      start_q  <= '0;
      tline_q  <= '0;
      offset_q <= '0;
      lines_q  <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      value_q  <= value_d;
      length_q <= length_d;
      cand_q   <= cand_d;
      op_q     <= op_d;
      start_q  <= start_d;
      tline_q  <= tline_d;
      offset_q <= offset_d;
      lines_q  <= lines_d;
    end
  end

  // Token queue: four entries, room for two is needed to take a byte.
  tok_t       fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] count_q;
  logic       pop;
  logic [1:0] push;

  assign in_i.ready = (count_q <= 3'd2);
  assign pop        = out_o.valid && out_o.ready;
  assign push       = accept ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= 2'(wr_q + push);
      rd_q    <= 2'(rd_q + {1'b0, pop});
      count_q <= 3'(count_q + {1'b0, push} - {2'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push != 2'd0) fifo_q[wr_q] <= r0;
    if (push == 2'd2) fifo_q[2'(wr_q + 2'd1)] <= r1;
  end

  // Output channel.
  assign out_o.valid         = (count_q != 3'd0);
  assign out_o.kind          = fifo_q[rd_q].kind;
  assign out_o.keyword_index = fifo_q[rd_q].keyword_index;
  assign out_o.number_value  = fifo_q[rd_q].number_value;
  assign out_o.text_length   = fifo_q[rd_q].text_length;
  assign out_o.line_number   = fifo_q[rd_q].line_number;
  assign out_o.start_offset  = fifo_q[rd_q].start_offset;
  assign out_o.last          = fifo_q[rd_q].last;

  // Checks.
  `CLST_ASSERT_IMP(a_fill_bound, 1'b1, count_q <= 3'd4, "token queue overfilled")
  `CLST_ASSERT_NXT(a_end_clears, accept && in_i.is_end,
                   offset_q == 32'd0 && lines_q == 32'd0 && mode_q == M_IDLE,
                   "end item did not clear the scanner")
  `CLST_ASSERT_NXT(a_offset_step, accept && !in_i.is_end,
                   offset_q == 32'($past(offset_q) + 32'd1),
                   "byte offset did not advance by one")
  `CLST_ASSERT_NXT(a_end_emits, accept && in_i.is_end, count_q != 3'd0,
                   "end item produced no token")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import clst_pkg::*;

  // Scanner modes of the token predictor.
  typedef enum logic [3:0] {
    SM_IDLE, SM_IDENT, SM_DEC, SM_ZERO, SM_HEX, SM_OCT, SM_STR, SM_OP,
    SM_LINE, SM_BLOCK, SM_BSTAR
  } scan_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  clst_in_if  src_if ();
  clst_out_if tok_if ();

  c_like_source_tokenizer_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (src_if.sink),
    .out_o (tok_if.source)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state.
  scan_mode_e  mode_q;
  logic [31:0] acc_value;
  logic [15:0] acc_length;
  logic [15:0] kw_cand;
  logic [4:0]  op_kind;
  logic [31:0] tok_start;
  logic [31:0] tok_line;
  logic [31:0] offset_q;
  logic [31:0] lines_q;

  tok_t expected_tokens[$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   recv_hold = 1'b0;
  int   hold_cycles = 0;

  function automatic string kw_word(input int idx);
    string words[16] = '{"if", "else", "for", "do", "while", "char", "int", "return",
                         "quit", "print", "read", "break", "begin", "function",
                         "interprete", "end"};
    return words[idx];
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic push_token(input logic [4:0] kind, input logic [3:0] kw,
                            input logic [31:0] val, input logic [15:0] len,
                            input logic [31:0] line, input logic [31:0] start);
    tok_t t;
    t = '{kind, kw, val, len, line, start, 1'b0};
    expected_tokens.push_back(t);
  endtask

  task automatic clear_scanner();
    mode_q = SM_IDLE;
    acc_value = '0;
    acc_length = '0;
    kw_cand = 16'hFFFF;
    op_kind = '0;
    tok_start = '0;
    tok_line = '0;
    offset_q = '0;
    lines_q = '0;
  endtask

  // Emit whatever token is in progress and return to idle.
  task automatic flush_token();
    bit found;
    found = 1'b0;
    case (mode_q)
      SM_IDENT: begin
        for (int i = 0; i < 16; i++) begin
          if (!found && kw_cand[i] && kw_word(i).len() == acc_length) begin
            push_token(K_KEYWORD, i[3:0], '0, acc_length, tok_line, tok_start);
            found = 1'b1;
          end
        end
        if (!found) push_token(K_IDENT, '0, '0, acc_length, tok_line, tok_start);
      end
      SM_DEC, SM_ZERO, SM_HEX, SM_OCT:
        push_token(K_NUMBER, '0, acc_value, '0, tok_line, tok_start);
      SM_STR: push_token(K_STRING, '0, '0, acc_length, tok_line, tok_start);
      SM_OP: push_token(op_kind, '0, '0, '0, tok_line, tok_start);
      default: ;
    endcase
    mode_q = SM_IDLE;
  endtask

  function automatic int hex_digit(input logic [7:0] b);
    if (is_num(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic bump_len();
    if (acc_length != 16'hFFFF) acc_length++;
  endtask

  // Offer the byte to the token in progress; returns 1 if absorbed.
  task automatic extend_token(input logic [7:0] b, output bit taken);
    string w;
    int h;
    int p;
    taken = 1'b1;
    case (mode_q)
      SM_IDENT: begin
        if (is_letter(b) || is_num(b) || b == "_") begin
          p = acc_length;
          for (int i = 0; i < 16; i++) begin
            w = kw_word(i);
            if (!(p < w.len() && w[p] == b)) kw_cand[i] = 1'b0;
          end
          bump_len();
          return;
        end
      end
      SM_DEC: if (is_num(b)) begin
        acc_value = acc_value * 10 + (b - "0");
        return;
      end
      SM_ZERO: begin
        if (b == "x" || b == "X") begin
          mode_q = SM_HEX;
          return;
        end
        if (b >= "0" && b <= "7") begin
          mode_q = SM_OCT;
          acc_value = acc_value * 8 + (b - "0");
          return;
        end
      end
      SM_HEX: begin
        h = hex_digit(b);
        if (h >= 0) begin
          acc_value = acc_value * 16 + h;
          return;
        end
      end
      SM_OCT: if (b >= "0" && b <= "7") begin
        acc_value = acc_value * 8 + (b - "0");
        return;
      end
      SM_STR: begin
        if (b == "\"") flush_token();
        else bump_len();
        return;
      end
      SM_OP: begin
        if (op_kind == K_DIV && b == "/") begin
          mode_q = SM_LINE;
          return;
        end
        if (op_kind == K_DIV && b == "*") begin
          mode_q = SM_BLOCK;
          return;
        end
        if (b == "=") begin
          case (op_kind)
            K_ADD: push_token(K_ADD_EQ, '0, '0, '0, tok_line, tok_start);
            K_SUB: push_token(K_SUB_EQ, '0, '0, '0, tok_line, tok_start);
            K_MUL: push_token(K_MUL_EQ, '0, '0, '0, tok_line, tok_start);
            K_DIV: push_token(K_DIV_EQ, '0, '0, '0, tok_line, tok_start);
            K_ASSIGN: push_token(K_EQ, '0, '0, '0, tok_line, tok_start);
            K_LT: push_token(K_LE, '0, '0, '0, tok_line, tok_start);
            K_GT: push_token(K_GE, '0, '0, '0, tok_line, tok_start);
            default: push_token(K_NE, '0, '0, '0, tok_line, tok_start);
          endcase
          mode_q = SM_IDLE;
          return;
        end
      end
      SM_LINE: begin
        if (b == "\n") mode_q = SM_IDLE;
        return;
      end
      SM_BLOCK: begin
        if (b == "*") mode_q = SM_BSTAR;
        return;
      end
      SM_BSTAR: begin
        mode_q = (b == "/") ? SM_IDLE : (b == "*") ? SM_BSTAR : SM_BLOCK;
        return;
      end
      default: begin
        taken = 1'b0;
        return;
      end
    endcase
    flush_token();
    taken = 1'b0;
  endtask

  task automatic begin_token(input logic [7:0] b);
    string w;
    tok_start = offset_q;
    tok_line = lines_q;
    acc_value = '0;
    acc_length = '0;
    if (b == " " || b == "\t" || b == "\n") return;
    if (is_letter(b) || b == "_") begin
      kw_cand = '0;
      for (int i = 0; i < 16; i++) begin
        w = kw_word(i);
        if (w[0] == b) kw_cand[i] = 1'b1;
      end
      acc_length = 16'd1;
      mode_q = SM_IDENT;
      return;
    end
    if (is_num(b)) begin
      acc_value = b - "0";
      mode_q = (b == "0") ? SM_ZERO : SM_DEC;
      return;
    end
    mode_q = SM_OP;
    case (b)
      "\"": mode_q = SM_STR;
      ";": begin push_token(K_SEMI, '0, '0, '0, tok_line, tok_start); mode_q = SM_IDLE; end
      "(": begin push_token(K_LPAREN, '0, '0, '0, tok_line, tok_start); mode_q = SM_IDLE; end
      ")": begin push_token(K_RPAREN, '0, '0, '0, tok_line, tok_start); mode_q = SM_IDLE; end
      "{": begin push_token(K_LBRACE, '0, '0, '0, tok_line, tok_start); mode_q = SM_IDLE; end
      "}": begin push_token(K_RBRACE, '0, '0, '0, tok_line, tok_start); mode_q = SM_IDLE; end
      "+": op_kind = K_ADD;
      "-": op_kind = K_SUB;
      "*": op_kind = K_MUL;
      "/": op_kind = K_DIV;
      "=": op_kind = K_ASSIGN;
      "<": op_kind = K_LT;
      ">": op_kind = K_GT;
      "!": op_kind = K_UNKNOWN;
      default: begin
        push_token(K_UNKNOWN, '0, '0, '0, tok_line, tok_start);
        mode_q = SM_IDLE;
      end
    endcase
  endtask

  // Work out the tokens one accepted item causes.
  task automatic predict_tokens(input logic [7:0] b, input logic eos);
    int n_prior;
    bit taken;
    n_prior = expected_tokens.size();
    if (eos) begin
      flush_token();
      push_token(K_END, '0, '0, '0, lines_q, offset_q);
      clear_scanner();
    end else begin
      extend_token(b, taken);
      if (!taken) begin_token(b);
      if (b == "\n") lines_q++;
      offset_q++;
    end
    if (expected_tokens.size() > n_prior) expected_tokens[$].last = 1'b1;
  endtask

  // Send one item, idling before it at the current rate. The valid line stays
  // high after acceptance so that the next item can follow without a gap.
  task automatic send_item(input logic [7:0] b, input logic eos);
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    if (idle > 0) begin
      src_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    src_if.valid <= 1'b1;
    src_if.byte_req <= b;
    src_if.is_end <= eos;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    predict_tokens(b, eos);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Drop the valid line and wait until every expected token has come.
  task automatic wait_drained();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall.
  always @(posedge clk_i) begin
    if (recv_hold) tok_if.ready <= 1'b0;
    else tok_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted token with the oldest expected one.
  always @(posedge clk_i) begin
    tok_t e;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d", tok_if.kind);
        fail_count++;
      end else begin
        e = expected_tokens.pop_front();
        if (tok_if.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, tok_if.kind); fail_count++;
        end
        if (tok_if.keyword_index !== e.keyword_index) begin
          $error("keyword_index: expected %0d, got %0d", e.keyword_index,
                 tok_if.keyword_index); fail_count++;
        end
        if (tok_if.number_value !== e.number_value) begin
          $error("number_value: expected %0h, got %0h", e.number_value,
                 tok_if.number_value); fail_count++;
        end
        if (tok_if.text_length !== e.text_length) begin
          $error("text_length: expected %0d, got %0d", e.text_length,
                 tok_if.text_length); fail_count++;
        end
        if (tok_if.line_number !== e.line_number) begin
          $error("line_number: expected %0d, got %0d", e.line_number,
                 tok_if.line_number); fail_count++;
        end
        if (tok_if.start_offset !== e.start_offset) begin
          $error("start_offset: expected %0d, got %0d", e.start_offset,
                 tok_if.start_offset); fail_count++;
        end
        if (tok_if.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, tok_if.last); fail_count++;
        end
      end
    end
  end

  // Directed: keywords, numbers, operators, comments, strings, odd bytes and end items.
  task automatic test_directed();
    send_text("if x1 interprete0 0x1F 017 089 12ab");
    send_text(" += -= *= /= == <= >= != ! / * + - = < > ;(){}");
    send_text("// note\n/* a * b **/ \"str\n\" \r");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("0x 0xFFFFFFFFF \"open");
    send_item(8'h00, 1'b1);
    send_text("/* unterminated");
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  // Random source text: mostly well formed fragments, some raw bytes and end items.
  task automatic test_random(input int count);
    string frags[24] = '{"if", "else", "for", "do", "while", "char", "int", "return",
                         "quit", "print", "read", "break", "begin", "function",
                         "interprete", "end", "foo_9", "0x7aF", "0755", "12345",
                         "\"hi\"", "/* c */", "// l\n", "beginx"};
    string ops = " \t\n;(){}+-*/=<>!\"_09xX";
    int n;
    int sel;
    string f;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        f = frags[$urandom_range(23)];
        send_text(f);
        n += f.len();
      end else if (sel < 8) begin
        send_item(ops[$urandom_range(ops.len() - 1)], 1'b0);
        n++;
      end else if (sel < 9) begin
        send_item(8'($urandom_range(255)), 1'b0);
        n++;
      end else begin
        send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
        n++;
      end
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Receiver holds off long enough for the input to back up.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 60) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        recv_hold = 1'b0;
      end
      send_text(";;;;;;;;;;(((((((())))))))+=");
    join
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  initial begin
    src_if.valid = 1'b0;
    src_if.byte_req = '0;
    src_if.is_end = 1'b0;
    tok_if.ready = 1'b0;
    clear_scanner();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(120);
    send_idle_pct = 71;
    test_random(120);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 71;
    test_random(120);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    test_random(120);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
